// ===== rtl/kceg_pkg.sv =====
// Package for the key change event generator.
// Shared constants, register indexes and the code-base struct.
// No dependencies.
package kceg_pkg;

  // M1, M2, M3, MR lead the key layout
  localparam int M_KEYS = 4;

  localparam logic [7:0] G_CODE_BASE_RST = 8'd167;
  localparam logic [7:0] M_CODE_BASE_RST = 8'd185;
  localparam logic [7:0] L_CODE_BASE_RST = 8'd189;

  // result kinds
  localparam logic KIND_KEY = 1'b0;
  localparam logic KIND_LED = 1'b1;

  typedef enum logic [1:0] {
    REG_G_CODE_BASE = 2'd0,
    REG_M_CODE_BASE = 2'd1,
    REG_L_CODE_BASE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] g_base;
    logic [7:0] m_base;
    logic [7:0] l_base;
  } code_bases_t;

endpackage

// ===== rtl/kceg_if.sv =====
// Channel interfaces: key snapshots in, events out.
// Valid/ready handshake; depends on nothing.
interface kceg_key_if #(parameter int KEY_W = 27);
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_state;

  modport source (output valid, output key_state, input ready);
  modport sink   (input valid, input key_state, output ready);
endinterface

interface kceg_evt_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] key_code;
  logic       pressed;
  logic [3:0] led_mask;
  logic       last;

  modport source (output valid, output kind, output key_code, output pressed,
                  output led_mask, output last, input ready);
  modport sink   (input valid, input kind, input key_code, input pressed,
                  input led_mask, input last, output ready);
endinterface

// ===== rtl/kceg_fifo.sv =====
// Two-entry flop queue between front and back.
// Generic payload width; no package dependency.
module kceg_fifo #(
  parameter int W = 54
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  input  logic [W-1:0] wr_data,
  output logic         full,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_wr, do_rd;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== rtl/kceg_front.sv =====
// Front end: takes snapshots, works out the change mask, queues changed ones.
// Depends on kceg_pkg and kceg_key_if.
module kceg_front
  import kceg_pkg::*;
#(
  parameter int G_KEYS = 18,
  parameter int L_KEYS = 5,
  localparam int KEY_W = M_KEYS + G_KEYS + L_KEYS
) (
  input  logic               clk,
  input  logic               rst_n,
  kceg_key_if.sink           in_key,
  output logic               q_wr_valid,
  output logic [2*KEY_W-1:0] q_wr_data,
  input  logic               q_full
);

  logic [KEY_W-1:0] prev_r;
  logic             accept;

  assign in_key.ready = !q_full;
  assign accept       = in_key.valid && in_key.ready;
  // unchanged snapshot gives no results, so nothing is queued
  assign q_wr_valid   = accept && (in_key.key_state != prev_r);
  assign q_wr_data    = {in_key.key_state, in_key.key_state ^ prev_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (accept) begin
      prev_r <= in_key.key_state;
    end
  end

endmodule

// ===== rtl/kceg_back.sv =====
// Back end: walks the change mask one key per cycle, stalling on out_evt, and emits events.
// Depends on kceg_pkg and kceg_evt_if; holds bank and record state.
module kceg_back
  import kceg_pkg::*;
#(
  parameter int G_KEYS = 18,
  parameter int L_KEYS = 5,
  localparam int KEY_W = M_KEYS + G_KEYS + L_KEYS,
  localparam int IW    = $clog2(KEY_W)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  code_bases_t        bases,
  input  logic               q_rd_valid,
  output logic               q_rd_ready,
  input  logic [2*KEY_W-1:0] q_rd_data,
  kceg_evt_if.source         out_evt
);

  localparam logic [IW-1:0] M_END = IW'(M_KEYS);
  localparam logic [IW-1:0] G_END = IW'(M_KEYS + G_KEYS);
  localparam logic [IW-1:0] MR_IDX = IW'(3);
  localparam logic [7:0]    L_OFS = 8'(M_KEYS + G_KEYS);

  logic             busy_r, busy_nxt;
  logic             led_done_r, led_done_nxt;
  logic [KEY_W-1:0] chg_r, chg_nxt;
  logic [KEY_W-1:0] now_r, now_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [2:0]       bank_r, bank_nxt;
  logic             rec_r, rec_nxt;

  logic             ov_r, ov_nxt;
  logic             kind_r, kind_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             pressed_r, pressed_nxt;
  logic [3:0]       led_r, led_nxt;
  logic             last_r, last_nxt;

  logic             adv, cur_chg, cur_on, m_press;
  logic [KEY_W-1:0] rest;
  logic [7:0]       idx8, key_code;
  logic [2:0]       bank_new;
  logic             rec_new;

  assign adv     = !ov_r || out_evt.ready;
  assign cur_chg = chg_r[idx_r];
  assign cur_on  = now_r[idx_r];
  assign m_press = cur_on && (idx_r < M_END);
  assign rest    = chg_r & ~(KEY_W'(1) << idx_r);
  assign idx8    = 8'(idx_r);

  assign q_rd_ready = !busy_r;

  always_comb begin
    priority if (idx_r < M_END) key_code = bases.m_base + idx8;
    else if (idx_r < G_END)     key_code = bases.g_base + idx8 - 8'(M_KEYS);
    else                        key_code = bases.l_base + idx8 - L_OFS;
  end

  // MR toggles record; M1..M3 select a one-hot bank
  always_comb begin
    if (idx_r == MR_IDX) begin
      bank_new = bank_r;
      rec_new  = ~rec_r;
    end else begin
      bank_new = 3'b001 << idx_r[1:0];
      rec_new  = rec_r;
    end
  end

  always_comb begin
    busy_nxt     = busy_r;
    led_done_nxt = led_done_r;
    chg_nxt      = chg_r;
    now_nxt      = now_r;
    idx_nxt      = idx_r;
    bank_nxt     = bank_r;
    rec_nxt      = rec_r;
    ov_nxt       = ov_r && !out_evt.ready;
    kind_nxt     = kind_r;
    code_nxt     = code_r;
    pressed_nxt  = pressed_r;
    led_nxt      = led_r;
    last_nxt     = last_r;

    if (!busy_r) begin
      if (q_rd_valid) begin
        busy_nxt     = 1'b1;
        led_done_nxt = 1'b0;
        chg_nxt      = q_rd_data[KEY_W-1:0];
        now_nxt      = q_rd_data[2*KEY_W-1:KEY_W];
        idx_nxt      = '0;
      end
    end else if (!cur_chg) begin
      idx_nxt = idx_r + IW'(1);
    end else if (adv) begin
      ov_nxt = 1'b1;
      if (m_press && !led_done_r) begin
        bank_nxt     = bank_new;
        rec_nxt      = rec_new;
        led_done_nxt = 1'b1;
        kind_nxt     = KIND_LED;
        code_nxt     = '0;
        pressed_nxt  = 1'b0;
        led_nxt      = {rec_new, bank_new};
        last_nxt     = 1'b0;
      end else begin
        led_done_nxt = 1'b0;
        chg_nxt      = rest;
        idx_nxt      = idx_r + IW'(1);
        kind_nxt     = KIND_KEY;
        code_nxt     = key_code;
        pressed_nxt  = cur_on;
        led_nxt      = '0;
        last_nxt     = (rest == '0);
        busy_nxt     = (rest != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      led_done_r <= 1'b0;
      bank_r     <= 3'b001;
      rec_r      <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      led_done_r <= led_done_nxt;
      bank_r     <= bank_nxt;
      rec_r      <= rec_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chg_r     <= chg_nxt;
    now_r     <= now_nxt;
    idx_r     <= idx_nxt;
    kind_r    <= kind_nxt;
    code_r    <= code_nxt;
    pressed_r <= pressed_nxt;
    led_r     <= led_nxt;
    last_r    <= last_nxt;
  end

  assign out_evt.valid    = ov_r;
  assign out_evt.kind     = kind_r;
  assign out_evt.key_code = code_r;
  assign out_evt.pressed  = pressed_r;
  assign out_evt.led_mask = led_r;
  assign out_evt.last     = last_r;

  // an LED write is always followed by its key-down event
  a_led_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && kind_r == KIND_LED) |-> !last_r)
    else $error("LED write marked as last");

  a_bank_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(bank_r))
    else $error("bank select not one-hot");

  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (chg_r != '0))
    else $error("busy with an empty change mask");

  a_led_pending: assert property (@(posedge clk) disable iff (!rst_n)
    led_done_r |-> (busy_r && cur_chg && m_press))
    else $error("pending key event lost after LED write");

endmodule

// ===== rtl/key_change_event_generator_top.sv =====
// Top level of the key change event generator: APB code-base registers,
// front end, queue and back end. Depends on kceg_pkg, kceg_if, kceg_fifo,
// kceg_front and kceg_back.
//
// Each accepted snapshot is compared with the one before; a snapshot with no
// change gives no events and is not queued. A changed snapshot goes into a
// two-entry queue and the back end walks it one key per cycle, holding on a
// changed key while the output stalls, in order M1, M2, M3, MR, G1.., L1..,
// emitting one transfer per changed key plus an LED write ahead of each
// M1/M2/M3/MR press. The back end takes the next snapshot only once it has
// issued the last transfer of the one before; the front end keeps taking
// snapshots while the queue has room. The final transfer of each snapshot
// carries last. Code bases are written over APB at 0x0 (G), 0x4 (M) and 0x8
// (L); write them only while no events are outstanding.
module key_change_event_generator_top
  import kceg_pkg::*;
#(
  parameter int G_KEYS = 18,
  parameter int L_KEYS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  kceg_key_if.sink    in_key,
  kceg_evt_if.source  out_evt,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KEY_W = M_KEYS + G_KEYS + L_KEYS;

  code_bases_t        bases_r;
  logic               q_wr_valid, q_full, q_rd_valid, q_rd_ready;
  logic [2*KEY_W-1:0] q_wr_data, q_rd_data;
  logic               cfg_wr;
  reg_idx_t           reg_sel;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bases_r.g_base <= G_CODE_BASE_RST;
      bases_r.m_base <= M_CODE_BASE_RST;
      bases_r.l_base <= L_CODE_BASE_RST;
    end else if (cfg_wr) begin
      // writes above the register list are dropped
      unique case (reg_sel)
        REG_G_CODE_BASE: bases_r.g_base <= pwdata[7:0];
        REG_M_CODE_BASE: bases_r.m_base <= pwdata[7:0];
        REG_L_CODE_BASE: bases_r.l_base <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_G_CODE_BASE: prdata = {24'd0, bases_r.g_base};
      REG_M_CODE_BASE: prdata = {24'd0, bases_r.m_base};
      REG_L_CODE_BASE: prdata = {24'd0, bases_r.l_base};
      default:         prdata = '0;
    endcase
  end

  // ---- front: change detection ----
  kceg_front #(.G_KEYS(G_KEYS), .L_KEYS(L_KEYS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_key     (in_key),
    .q_wr_valid (q_wr_valid),
    .q_wr_data  (q_wr_data),
    .q_full     (q_full)
  );

  // ---- queue: {snapshot, change mask} ----
  kceg_fifo #(.W(2*KEY_W)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  // ---- back: event sequencing ----
  kceg_back #(.G_KEYS(G_KEYS), .L_KEYS(L_KEYS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bases      (bases_r),
    .q_rd_valid (q_rd_valid),
    .q_rd_ready (q_rd_ready),
    .q_rd_data  (q_rd_data),
    .out_evt    (out_evt)
  );

endmodule
